// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the grid tile packer checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while dis is high.
`define FFGP_ASSERT_IMPL(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("grid tile packer check failed");

// Next-cycle implication, disabled while dis is high.
`define FFGP_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("grid tile packer check failed");

`endif

// File: rtl/ffgp_pkg.sv
// ----------------------------------------------------------------------------
// ffgp_pkg
// Field widths, codes, footprint tables and shared types of the tile packer.
// ----------------------------------------------------------------------------
package ffgp_pkg;

  localparam int CMD_W      = 1;
  localparam int SIZE_W     = 2;
  localparam int POS_X_W    = 12;
  localparam int POS_Y_W    = 15;
  localparam int SPAN_W     = 12;
  localparam int USED_W     = 15;
  localparam int GCOL_W     = 4;
  localparam int CELL_W     = 8;
  localparam int GAP_W      = 6;
  localparam int PITCH_W    = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int FOOT_W     = 3;

  localparam int SHORT_MAX = 4095;
  localparam int LONG_MAX  = 32767;

  localparam logic [CMD_W-1:0] CMD_PLACE = 1'b0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 1'b1;

  localparam logic [SIZE_W-1:0] SZ_SMALL  = 2'd0;
  localparam logic [SIZE_W-1:0] SZ_MEDIUM = 2'd1;
  localparam logic [SIZE_W-1:0] SZ_WIDE   = 2'd2;
  localparam logic [SIZE_W-1:0] SZ_LARGE  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_PIXELS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_PIXELS   = 2'd2;

  localparam logic [GCOL_W-1:0] GCOL_RST = 4'd6;
  localparam logic [CELL_W-1:0] CELL_RST = 8'd100;
  localparam logic [GAP_W-1:0]  GAP_RST  = 6'd4;

  typedef logic [FOOT_W-1:0] foot_t;

  // One request to the shared pixel unit.
  typedef struct packed {
    logic              span;
    logic [CELL_W-1:0] cell_len;
    logic [GAP_W-1:0]  gap;
  } pix_op_t;

  function automatic foot_t tile_w(input logic [SIZE_W-1:0] code);
    foot_t w;
    case (code)
      SZ_SMALL:  w = 3'd1;
      SZ_MEDIUM: w = 3'd2;
      SZ_WIDE:   w = 3'd4;
      SZ_LARGE:  w = 3'd4;
      default:   w = 3'd1;
    endcase
    return w;
  endfunction

  function automatic foot_t tile_h(input logic [SIZE_W-1:0] code);
    foot_t h;
    case (code)
      SZ_SMALL:  h = 3'd1;
      SZ_MEDIUM: h = 3'd2;
      SZ_WIDE:   h = 3'd2;
      SZ_LARGE:  h = 3'd4;
      default:   h = 3'd1;
    endcase
    return h;
  endfunction

endpackage

// File: rtl/ffgp_if.sv
// ----------------------------------------------------------------------------
// ffgp_if
// Command and result channels of the tile packer, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ffgp_cmd_if;
  import ffgp_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [SIZE_W-1:0] tile_size;
  modport source (output valid, command, tile_size, input ready);
  modport sink   (input valid, command, tile_size, output ready);
endinterface

interface ffgp_res_if;
  import ffgp_pkg::*;
  logic               valid;
  logic               ready;
  logic [POS_X_W-1:0] pos_x;
  logic [POS_Y_W-1:0] pos_y;
  logic [SPAN_W-1:0]  size_w;
  logic [SPAN_W-1:0]  size_h;
  logic [USED_W-1:0]  used_height;
  logic               grid_full;
  modport source (output valid, pos_x, pos_y, size_w, size_h, used_height, grid_full,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, size_w, size_h, used_height, grid_full,
                  output ready);
endinterface

// File: rtl/first_fit_grid_tile_packer_top.sv
// ----------------------------------------------------------------------------
// first_fit_grid_tile_packer_top
// First-fit packer of square and wide tiles into a column-bounded cell grid.
// ----------------------------------------------------------------------------
//
//   channel | dir | beat contents                                   | handshake
//   --------+-----+-------------------------------------------------+----------
//   cmd     | in  | command, tile_size                              | valid/ready
//   res     | out | pos_x, pos_y, size_w, size_h, used_height, full | valid/ready
//   cfg_*   | in  | cfg_index, cfg_data                             | cfg_we only
//
// A clear beat goes from idle straight to the emit state. A place beat scans,
// writes back and runs the pixel passes: rows are streamed through the single
// bitmap read port (first fitting row + tile height, at most MAX_ROWS), the
// tile rows are written back on the single write port (none when full), and
// the shared multiplier makes 5 passes. Reset is synchronous and empties the
// grid at once through per-row valid bits. cmd is ready only between items; a
// finished result waits in the res register while the next command beat is taken.
//
module first_fit_grid_tile_packer_top #(
  parameter int MAX_COLUMNS = 8,
  parameter int MAX_ROWS    = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  ffgp_cmd_if.sink                         cmd,
  ffgp_res_if.source                       res,
  input  logic                             cfg_we,
  input  logic [ffgp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ffgp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ffgp_pkg::*;

  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int RU_W  = $clog2(MAX_ROWS + 1);
  localparam int COL_W = $clog2(MAX_COLUMNS);
  localparam int CNT_W = $clog2(MAX_COLUMNS + 1);
  localparam int N_A   = (RU_W > COL_W) ? RU_W : COL_W;
  localparam int N_W   = (N_A > FOOT_W) ? N_A : FOOT_W;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_WRITE = 3'd2;
  localparam logic [2:0] S_PIX   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  // pixel unit passes
  localparam logic [2:0] P_POS_X  = 3'd0;
  localparam logic [2:0] P_POS_Y  = 3'd1;
  localparam logic [2:0] P_SIZE_W = 3'd2;
  localparam logic [2:0] P_SIZE_H = 3'd3;
  localparam logic [2:0] P_USED   = 3'd4;

  // configuration
  logic [GCOL_W-1:0] grid_columns;
  logic [CELL_W-1:0] cell_pixels;
  logic [GAP_W-1:0]  gap_pixels;
  logic [CNT_W-1:0]  cols_eff;

  // sequencer and search state
  logic [2:0]             state;
  foot_t                  tw;
  foot_t                  th;
  logic [ROW_W-1:0]       raddr;
  logic                   issue_done;
  logic                   dvld;
  logic [ROW_W-1:0]       drow;
  logic [MAX_COLUMNS-1:0] win [3];
  logic [MAX_COLUMNS-1:0] wb  [4];
  logic [1:0]             wcnt;
  logic [COL_W-1:0]       fcol;
  logic [ROW_W-1:0]       frow;
  logic                   found;
  logic [RU_W-1:0]        rows_in_use;
  logic [2:0]             pstep;

  // staged result
  logic [POS_X_W-1:0] rx;
  logic [POS_Y_W-1:0] ry;
  logic [SPAN_W-1:0]  rw;
  logic [SPAN_W-1:0]  rh;
  logic [USED_W-1:0]  rused;
  logic               rfull;

  // datapath
  logic [MAX_COLUMNS-1:0] rd_data;
  logic [MAX_COLUMNS-1:0] acc;
  logic                   fit_found;
  logic [COL_W-1:0]       fit_col;
  logic [MAX_COLUMNS-1:0] fit_mask;
  logic                   cand_ok;
  logic                   hit;
  logic                   mem_we;
  logic [ROW_W-1:0]       mem_waddr;
  logic                   grid_clr;
  logic [N_W-1:0]         pix_n;
  pix_op_t                pix_op;
  logic [SPAN_W-1:0]      pix_short;
  logic [USED_W-1:0]      pix_long;
  logic [RU_W-1:0]        row_end;
  foot_t                  w_raw;

  // configuration writes: indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns <= GCOL_RST;
      cell_pixels  <= CELL_RST;
      gap_pixels   <= GAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_COLUMNS: grid_columns <= cfg_data[GCOL_W-1:0];
        REG_CELL_PIXELS:  cell_pixels  <= cfg_data[CELL_W-1:0];
        REG_GAP_PIXELS:   gap_pixels   <= cfg_data[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // zero columns behaves as one, excess saturates at the bitmap width
  always_comb begin
    if (grid_columns == '0) begin
      cols_eff = CNT_W'(1);
    end else if (32'(grid_columns) > 32'(MAX_COLUMNS)) begin
      cols_eff = CNT_W'(MAX_COLUMNS);
    end else begin
      cols_eff = CNT_W'(grid_columns);
    end
  end

  assign cmd.ready = (state == S_IDLE);
  assign grid_clr  = cmd.valid && cmd.ready && (cmd.command == CMD_CLEAR);
  assign w_raw     = tile_w(cmd.tile_size);

  assign mem_we    = (state == S_WRITE);
  assign mem_waddr = drow - ROW_W'(wcnt);

  ffgp_occ_mem #(
    .ROWS (MAX_ROWS),
    .COLS (MAX_COLUMNS)
  ) u_occ_mem (
    .clk     (clk),
    .rst     (rst),
    .clr     (grid_clr),
    .rd_addr (raddr),
    .rd_data (rd_data),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (wb[wcnt])
  );

  // merge the newest row with the rows above it, as deep as the tile
  always_comb begin
    acc = rd_data;
    if (th > 3'd1) acc = acc | win[0];
    if (th > 3'd2) acc = acc | win[1];
    if (th > 3'd3) acc = acc | win[2];
  end

  assign row_end = RU_W'(drow) + RU_W'(1);
  assign cand_ok = dvld && (row_end >= RU_W'(th));
  assign hit     = cand_ok && fit_found;

  ffgp_fit_unit #(
    .COLS (MAX_COLUMNS)
  ) u_fit (
    .acc   (acc),
    .w     (tw),
    .cols  (cols_eff),
    .found (fit_found),
    .col   (fit_col),
    .mask  (fit_mask)
  );

  // operand select for the shared pixel unit; a miss feeds zero except for the used-height pass
  always_comb begin
    pix_op.cell_len = cell_pixels;
    pix_op.gap      = gap_pixels;
    pix_op.span     = 1'b1;
    pix_n           = '0;
    case (pstep)
      P_POS_X: begin
        pix_op.span = 1'b0;
        pix_n       = found ? N_W'(fcol) : '0;
      end
      P_POS_Y: begin
        pix_op.span = 1'b0;
        pix_n       = found ? N_W'(frow) : '0;
      end
      P_SIZE_W: pix_n = found ? N_W'(tw) : '0;
      P_SIZE_H: pix_n = found ? N_W'(th) : '0;
      P_USED:   pix_n = N_W'(rows_in_use);
      default:  pix_n = '0;
    endcase
  end

  ffgp_pix_unit #(
    .N_W (N_W)
  ) u_pix (
    .n         (pix_n),
    .op        (pix_op),
    .sat_short (pix_short),
    .sat_long  (pix_long)
  );

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      res.valid   <= 1'b0;
      rows_in_use <= '0;
      dvld        <= 1'b0;
      issue_done  <= 1'b0;
      found       <= 1'b0;
    end else begin
      if (res.valid && res.ready && (state != S_EMIT)) begin
        res.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            if (cmd.command == CMD_CLEAR) begin
              rows_in_use <= '0;
              found       <= 1'b0;
              rx          <= '0;
              ry          <= '0;
              rw          <= '0;
              rh          <= '0;
              rused       <= '0;
              rfull       <= 1'b0;
              state       <= S_EMIT;
            end else begin
              // clamp tile width to the column count
              if (CNT_W'(w_raw) > cols_eff) begin
                tw <= FOOT_W'(cols_eff);
              end else begin
                tw <= w_raw;
              end
              th         <= tile_h(cmd.tile_size);
              raddr      <= '0;
              issue_done <= 1'b0;
              dvld       <= 1'b0;
              found      <= 1'b0;
              state      <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // stream rows top-down, one read issued per cycle; hold the
          // bottom row of a hit for the write-back addresses
          dvld <= !issue_done && !hit;
          if (!hit) begin
            drow <= raddr;
          end
          if (!issue_done) begin
            if (raddr == ROW_W'(MAX_ROWS - 1)) begin
              issue_done <= 1'b1;
            end else begin
              raddr <= raddr + ROW_W'(1);
            end
          end
          if (dvld) begin
            win[0] <= rd_data;
            win[1] <= win[0];
            win[2] <= win[1];
            if (hit) begin
              found <= 1'b1;
              fcol  <= fit_col;
              frow  <= drow - ROW_W'(th) + ROW_W'(1);
              wb[0] <= rd_data | fit_mask;
              wb[1] <= win[0] | fit_mask;
              wb[2] <= win[1] | fit_mask;
              wb[3] <= win[2] | fit_mask;
              wcnt  <= '0;
              if (row_end > rows_in_use) begin
                rows_in_use <= row_end;
              end
              state <= S_WRITE;
            end else if (drow == ROW_W'(MAX_ROWS - 1)) begin
              pstep <= P_POS_X;
              state <= S_PIX;
            end
          end
        end
        S_WRITE: begin
          // write back from the bottom tile row upwards
          if (FOOT_W'(wcnt) + FOOT_W'(1) == th) begin
            pstep <= P_POS_X;
            state <= S_PIX;
          end else begin
            wcnt <= wcnt + 2'd1;
          end
        end
        S_PIX: begin
          pstep <= pstep + 3'd1;
          case (pstep)
            P_POS_X:  rx <= pix_short;
            P_POS_Y:  ry <= pix_long;
            P_SIZE_W: rw <= pix_short;
            P_SIZE_H: rh <= pix_short;
            default: begin
              rused <= pix_long;
              rfull <= !found;
              state <= S_EMIT;
            end
          endcase
        end
        S_EMIT: begin
          // hold until the result register is free
          if (!res.valid || res.ready) begin
            res.valid       <= 1'b1;
            res.pos_x       <= rx;
            res.pos_y       <= ry;
            res.size_w      <= rw;
            res.size_h      <= rh;
            res.used_height <= rused;
            res.grid_full   <= rfull;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/ffgp_occ_mem.sv
// ----------------------------------------------------------------------------
// ffgp_occ_mem
// Occupancy bitmap: one row word per entry, registered read, row valid bits.
// ----------------------------------------------------------------------------
module ffgp_occ_mem #(
  parameter int ROWS = 64,
  parameter int COLS = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    clr,
  input  logic [$clog2(ROWS)-1:0] rd_addr,
  output logic [COLS-1:0]         rd_data,
  input  logic                    wr_en,
  input  logic [$clog2(ROWS)-1:0] wr_addr,
  input  logic [COLS-1:0]         wr_data
);

  logic [COLS-1:0] mem [ROWS];
  logic [ROWS-1:0] row_vld;
  logic [COLS-1:0] rd_q;
  logic            rd_vld_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // an invalid row reads as empty
  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= row_vld[rd_addr];
      if (clr) begin
        row_vld <= '0;
      end else if (wr_en) begin
        row_vld[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

// File: rtl/ffgp_fit_unit.sv
// ----------------------------------------------------------------------------
// ffgp_fit_unit
// First free column of a merged row window for a tile of a given width.
// ----------------------------------------------------------------------------
module ffgp_fit_unit #(
  parameter int COLS = 8
) (
  input  logic [COLS-1:0]           acc,
  input  ffgp_pkg::foot_t           w,
  input  logic [$clog2(COLS+1)-1:0] cols,
  output logic                      found,
  output logic [$clog2(COLS)-1:0]   col,
  output logic [COLS-1:0]           mask
);
  import ffgp_pkg::*;

  localparam int CNT_W = $clog2(COLS + 1);
  localparam int COL_W = $clog2(COLS);

  logic [COLS-1:0] wmask;
  logic [COLS-1:0] fits;
  logic [CNT_W:0]  reach [COLS];

  always_comb begin
    wmask = '0;
    for (int i = 0; i < COLS; i++) begin
      if (CNT_W'(i) < CNT_W'(w)) begin
        wmask[i] = 1'b1;
      end
    end
  end

  always_comb begin
    for (int c = 0; c < COLS; c++) begin
      reach[c] = (CNT_W+1)'(c) + (CNT_W+1)'(w);
      fits[c]  = (reach[c] <= {1'b0, cols}) && ((acc & (wmask << c)) == '0);
    end
  end

  // lowest fitting column wins
  always_comb begin
    found = 1'b0;
    col   = '0;
    for (int c = COLS - 1; c >= 0; c--) begin
      if (fits[c]) begin
        found = 1'b1;
        col   = COL_W'(c);
      end
    end
    mask = wmask << col;
  end

endmodule

// File: rtl/ffgp_pix_unit.sv
// ----------------------------------------------------------------------------
// ffgp_pix_unit
// Shared pixel unit: n * (cell + gap), less one gap for spans, saturated.
// ----------------------------------------------------------------------------
module ffgp_pix_unit #(
  parameter int N_W = 7
) (
  input  logic [N_W-1:0]               n,
  input  ffgp_pkg::pix_op_t            op,
  output logic [ffgp_pkg::SPAN_W-1:0]  sat_short,
  output logic [ffgp_pkg::USED_W-1:0]  sat_long
);
  import ffgp_pkg::*;

  localparam int PROD_W = N_W + PITCH_W;

  logic [PITCH_W-1:0] pitch;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  val;
  logic [31:0]        val32;

  always_comb begin
    pitch = PITCH_W'(op.cell_len) + PITCH_W'(op.gap);
    prod  = PROD_W'(n) * PROD_W'(pitch);
    if (n == '0) begin
      val = '0;
    end else if (op.span) begin
      val = prod - PROD_W'(op.gap);
    end else begin
      val = prod;
    end
    val32     = 32'(val);
    sat_short = (val32 > 32'(SHORT_MAX)) ? SPAN_W'(SHORT_MAX) : val32[SPAN_W-1:0];
    sat_long  = (val32 > 32'(LONG_MAX))  ? USED_W'(LONG_MAX)  : val32[USED_W-1:0];
  end

endmodule

// File: rtl/ffgp_checker.sv
// ----------------------------------------------------------------------------
// ffgp_checker
// Port-level checks of the tile packer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ffgp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          cmd_valid,
  input logic                          cmd_ready,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic [ffgp_pkg::POS_X_W-1:0]  res_pos_x,
  input logic [ffgp_pkg::POS_Y_W-1:0]  res_pos_y,
  input logic [ffgp_pkg::SPAN_W-1:0]   res_size_w,
  input logic [ffgp_pkg::SPAN_W-1:0]   res_size_h,
  input logic                          res_grid_full
);
  import ffgp_pkg::*;

  // a full grid reports no rectangle
  `FFGP_ASSERT_IMPL(a_full_no_rect, clk, rst, res_valid && res_grid_full, res_pos_x == '0 && res_pos_y == '0 && res_size_w == '0 && res_size_h == '0)

  // one item at a time: busy right after a command beat
  `FFGP_ASSERT_NEXT(a_busy_after_cmd, clk, rst, cmd_valid && cmd_ready, !cmd_ready)

  // reset drops any pending result
  `FFGP_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !res_valid)

  // a stalled result stays offered
  `FFGP_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid)

endmodule

bind first_fit_grid_tile_packer_top ffgp_checker u_ffgp_checker (
  .clk           (clk),
  .rst           (rst),
  .cmd_valid     (cmd.valid),
  .cmd_ready     (cmd.ready),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .res_pos_x     (res.pos_x),
  .res_pos_y     (res.pos_y),
  .res_size_w    (res.size_w),
  .res_size_h    (res.size_h),
  .res_grid_full (res.grid_full)
);
